[hw/rtl/sqfe_pkg.sv]
// Shared widths and bundle types for the sliding quadratic fit block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sqfe_pkg;

  localparam int CFG_W    = 5;
  localparam int M0_W     = 32;
  localparam int M1_W     = 32;
  localparam int M2_W     = 40;
  localparam int EST_W    = 40;
  localparam int CNT_W    = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;
  localparam int HW_RESET = 4;

  // moment sums as held between the update stage and the estimate stage
  typedef struct packed {
    logic signed [M2_W-1:0] m2;
    logic signed [M1_W-1:0] m1;
    logic signed [M0_W-1:0] m0;
  } mom_t;

  // one finished result
  typedef struct packed {
    logic signed [EST_W-1:0] amp;
    logic signed [EST_W-1:0] slope;
    logic signed [EST_W-1:0] curv;
    logic                    curv_fell;
    logic                    curv_rose;
    logic                    peak_seen;
    logic [CNT_W-1:0]        center;
    logic                    full;
  } est_t;

endpackage

[hw/rtl/sliding_quadratic_fit_extrema.sv]
// Top level of the sliding quadratic fit with extremum flags.
// Depends on sqfe_pkg, sqfe_window (row of sqfe_cell) and sqfe_estimate.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------------------
//   in       | in_valid / in_stall      | in_sample
//   out      | out_valid / out_stall    | out_amp_estimate .. out_window_full
//   config   | psel/penable/pwrite/...  | half_width at byte address 0
//
// One request per cycle sustained while out_stall is low; after acceptance a request passes the
// moment update stage, then the estimate stage (two multipliers) into the output register.
// Synchronous active-low reset; a half_width write restarts the fit and clears
// the window cells in the same cycle.
// A held output stalls the input only when the update stage is also occupied.
`timescale 1ns / 1ps

module sliding_quadratic_fit_extrema
  import sqfe_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = 16,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [EST_W-1:0] out_amp_estimate,
  output logic signed [EST_W-1:0] out_slope_estimate,
  output logic signed [EST_W-1:0] out_curv_estimate,
  output logic                    out_curv_fell,
  output logic                    out_curv_rose,
  output logic                    out_peak_seen,
  output logic [CNT_W-1:0]        out_center_index,
  output logic                    out_window_full,

  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int DEPTH  = 2 * MAX_HALF_WIDTH + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int HW_W   = $clog2(MAX_HALF_WIDTH + 1);
  localparam int HW2_W  = 2 * HW_W;
  localparam int RW     = 2 * HW_W + 2;
  localparam int P2_W   = HW2_W + SB + 2;
  localparam int PL_W   = HW_W + 1 + SB;
  localparam int PS_W   = HW_W + SB + 2;
  localparam logic REG_HALF_WIDTH = 1'b0;

  typedef struct packed {
    logic [HW_W-1:0]  hw;
    logic [HW2_W-1:0] hw2;
    logic [RW-1:0]    r0;
    logic [RW-1:0]    r2;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] head;
  } geom_t;

  function automatic geom_t calc_geom(logic [CFG_W-1:0] v);
    geom_t g;
    logic [HW_W-1:0] h;
    if (v == '0) begin
      h = HW_W'(1);
    end else if (int'(v) > MAX_HALF_WIDTH) begin
      h = HW_W'(MAX_HALF_WIDTH);
    end else begin
      h = HW_W'(v);
    end
    g.hw   = h;
    g.hw2  = HW2_W'(h) * HW2_W'(h);
    g.r0   = RW'(g.hw2) + RW'(h);
    g.r2   = (g.r0 << 1) + g.r0 - RW'(1);
    g.len  = (LEN_W'(h) << 1) + LEN_W'(1);
    g.head = IDX_W'(h) << 1;
    return g;
  endfunction

  logic [CFG_W-1:0] half_width_r;
  geom_t            geom_r;
  logic             cfg_wr;

  logic             s1_valid_r;
  mom_t             mom_r;
  mom_t             mom_nxt;
  logic [LEN_W-1:0] fill_r;
  logic [CNT_W-1:0] cnt_r;
  logic             in_acc;
  logic             adv;
  logic [SB-1:0]    leave;
  est_t             res;

  logic signed [SB-1:0]    low_s;
  logic signed [SB-1:0]    high_s;
  logic signed [SB:0]      diff;
  logic signed [SB:0]      sum;
  logic signed [P2_W-1:0]  p_hw2_diff;
  logic signed [PL_W-1:0]  p_hw_low;
  logic signed [PS_W-1:0]  p_hw_sum;
  logic signed [M2_W-1:0]  y0;
  logic signed [M2_W-1:0]  y1;
  logic signed [M2_W-1:0]  y2;
  logic signed [M2_W-1:0]  subavg;
  logic signed [M2_W-1:0]  n0;
  logic signed [M2_W-1:0]  n1;
  logic signed [M2_W-1:0]  n2;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HALF_WIDTH);
  assign prdata = (paddr[2] == REG_HALF_WIDTH) ? DATA_W'(half_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= CFG_W'(HW_RESET);
      geom_r       <= calc_geom(CFG_W'(HW_RESET));
    end else if (cfg_wr) begin
      half_width_r <= pwdata[CFG_W-1:0];
      geom_r       <= calc_geom(pwdata[CFG_W-1:0]);
    end
  end

  // handshake
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  sqfe_window #(
    .DEPTH(DEPTH),
    .SB   (SB)
  ) u_window (
    .clk  (clk),
    .rst_n(rst_n),
    .clear(cfg_wr),
    .shift(in_acc),
    .head (geom_r.head),
    .din  (in_sample),
    .dout (leave)
  );

  // moment recurrence
  always_comb begin
    low_s      = $signed(leave);
    high_s     = $signed(in_sample);
    diff       = (SB+1)'(high_s) - (SB+1)'(low_s);
    sum        = (SB+1)'(high_s) + (SB+1)'(low_s);
    p_hw2_diff = $signed({1'b0, geom_r.hw2}) * diff;
    p_hw_low   = $signed({1'b0, geom_r.hw}) * low_s;
    p_hw_sum   = $signed({1'b0, geom_r.hw}) * sum;
    y0         = M2_W'(mom_r.m0);
    y1         = M2_W'(mom_r.m1);
    y2         = mom_r.m2;
    subavg     = y0 - M2_W'(low_s);
    n2         = y2 + M2_W'(p_hw2_diff) - ((y1 + M2_W'(p_hw_low)) <<< 1) + subavg;
    n1         = y1 + M2_W'(p_hw_sum) - subavg;
    n0         = y0 + M2_W'(diff);
    mom_nxt.m2 = n2;
    mom_nxt.m1 = n1[M1_W-1:0];
    mom_nxt.m0 = n0[M0_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mom_r      <= '0;
      fill_r     <= '0;
      cnt_r      <= '0;
    end else begin
      s1_valid_r <= in_acc || (s1_valid_r && !adv);
      if (cfg_wr) begin
        mom_r  <= '0;
        fill_r <= '0;
      end else if (in_acc) begin
        mom_r <= mom_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (fill_r < geom_r.len) begin
          fill_r <= fill_r + LEN_W'(1);
        end
      end
    end
  end

  sqfe_estimate #(
    .RW(RW)
  ) u_estimate (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cfg_wr),
    .s1_valid (s1_valid_r),
    .out_stall(out_stall),
    .mom      (mom_r),
    .r0       (geom_r.r0),
    .r2       (geom_r.r2),
    .cnt      (cnt_r),
    .full     (fill_r >= geom_r.len),
    .adv      (adv),
    .out_valid(out_valid),
    .res      (res)
  );

  assign out_amp_estimate   = res.amp;
  assign out_slope_estimate = res.slope;
  assign out_curv_estimate  = res.curv;
  assign out_curv_fell      = res.curv_fell;
  assign out_curv_rose      = res.curv_rose;
  assign out_peak_seen      = res.peak_seen;
  assign out_center_index   = res.center;
  assign out_window_full    = res.full;

endmodule

[hw/rtl/sqfe_cell.sv]
// One sample cell of the window shift line.
// Loads the new sample when it is the head cell, else its upper neighbor. Uses sqfe_pkg.
`timescale 1ns / 1ps

module sqfe_cell
  import sqfe_pkg::*;
#(
  parameter int SB = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          shift,
  input  logic          head,
  input  logic [SB-1:0] new_smp,
  input  logic [SB-1:0] nbr_smp,
  output logic [SB-1:0] smp_q
);

  logic [SB-1:0] smp_r;
  logic [SB-1:0] smp_nxt;

  always_comb begin
    smp_nxt = smp_r;
    if (clear) begin
      smp_nxt = '0;
    end else if (shift) begin
      smp_nxt = head ? new_smp : nbr_smp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
    end else begin
      smp_r <= smp_nxt;
    end
  end

  assign smp_q = smp_r;

endmodule

[hw/rtl/sqfe_window.sv]
// Row of sample cells holding the fit window; the oldest sample leaves at cell 0.
// Depends on sqfe_cell and sqfe_pkg.
`timescale 1ns / 1ps

module sqfe_window
  import sqfe_pkg::*;
#(
  parameter int DEPTH = 33,
  parameter int SB    = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  logic                     shift,
  input  logic [$clog2(DEPTH)-1:0] head,
  input  logic [SB-1:0]            din,
  output logic [SB-1:0]            dout
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [SB-1:0] smp [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SB-1:0] nbr;
    if (i == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = smp[i+1];
    end

    sqfe_cell #(
      .SB(SB)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clear  (clear),
      .shift  (shift),
      .head   (head == IDX_W'(i)),
      .new_smp(din),
      .nbr_smp(nbr),
      .smp_q  (smp[i])
    );
  end

  assign dout = smp[0];

endmodule

[hw/rtl/sqfe_estimate.sv]
// Output stage: amplitude, slope and curvature from the moment sums, sign-change flags,
// and the output register. Uses sqfe_pkg.
`timescale 1ns / 1ps

module sqfe_estimate
  import sqfe_pkg::*;
#(
  parameter int RW = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             s1_valid,
  input  logic             out_stall,
  input  mom_t             mom,
  input  logic [RW-1:0]    r0,
  input  logic [RW-1:0]    r2,
  input  logic [CNT_W-1:0] cnt,
  input  logic             full,
  output logic             adv,
  output logic             out_valid,
  output est_t             res
);

  localparam int PW = RW + 1 + M0_W;

  logic                    out_valid_r;
  est_t                    res_r;
  est_t                    res_nxt;
  logic                    prev_curv_pos_r;
  logic                    prev_slope_pos_r;
  logic                    load;
  logic signed [PW-1:0]    p_r2;
  logic signed [PW-1:0]    p_r0;
  logic signed [EST_W-1:0] y2;
  logic signed [EST_W-1:0] amp;
  logic signed [EST_W-1:0] curv;
  logic                    curv_pos;
  logic                    slope_pos;

  assign adv  = !out_valid_r || !out_stall;
  assign load = s1_valid && adv;

  always_comb begin
    p_r2      = $signed({1'b0, r2}) * mom.m0;
    p_r0      = $signed({1'b0, r0}) * mom.m0;
    y2        = EST_W'(mom.m2);
    amp       = EST_W'(p_r2) - ((y2 <<< 2) + y2);
    curv      = ((y2 <<< 1) + y2) - EST_W'(p_r0);
    curv_pos  = !curv[EST_W-1] && (|curv);
    slope_pos = !mom.m1[M1_W-1] && (|mom.m1);

    res_nxt.amp       = amp;
    res_nxt.slope     = EST_W'(mom.m1);
    res_nxt.curv      = curv;
    res_nxt.curv_fell = prev_curv_pos_r && curv[EST_W-1];
    res_nxt.curv_rose = !prev_curv_pos_r && curv_pos;
    res_nxt.peak_seen = prev_slope_pos_r && mom.m1[M1_W-1];
    res_nxt.center    = cnt;
    res_nxt.full      = full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r      <= 1'b0;
      prev_curv_pos_r  <= 1'b0;
      prev_slope_pos_r <= 1'b0;
    end else begin
      out_valid_r <= load || (out_valid_r && out_stall);
      if (clear) begin
        prev_curv_pos_r  <= 1'b0;
        prev_slope_pos_r <= 1'b0;
      end else if (load) begin
        prev_curv_pos_r  <= curv_pos;
        prev_slope_pos_r <= slope_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
